@@ src/tlvd_pkg.sv @@
package tlvd_pkg;

  localparam int unsigned TYPE_W = 13;
  localparam int unsigned LEN_W  = 16;

  localparam logic [TYPE_W-1:0] BLOCK_END_TYPE_RESET = 13'h0902;
  localparam logic [4:0]        SHORT_TYPE_MASK      = 5'h1f;

  localparam logic [1:0] ROLE_HEADER  = 2'd0;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd1;
  localparam logic [1:0] ROLE_END     = 2'd2;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_TRUNCATED    = 2'd1;
  localparam logic [1:0] STATUS_UNTERMINATED = 2'd2;
  localparam logic [1:0] STATUS_CLEAN_END    = 2'd3;

  typedef enum logic [4:0] {
    PH_H0  = 5'b00001,
    PH_H1  = 5'b00010,
    PH_H2  = 5'b00100,
    PH_H3  = 5'b01000,
    PH_PAY = 5'b10000
  } phase_t;

endpackage

@@ src/tlv8_tlv16_stream_deframer.sv @@
// a request's result is registered at the edge that accepts it and shows at the output in the next cycle
// throughput: one byte or end mark per cycle; in_ready drops only while a result is stalled
// the header/payload state machine feeds the result register
// rst (synchronous, active high) clears out_valid, returns the parser to the
// first header byte and loads block_end_type with 0x0902
module tlv8_tlv16_stream_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_role,
  output logic [12:0] element_type,
  output logic [2:0]  header_flags,
  output logic [15:0] element_length,
  output logic        element_done,
  output logic        block_done,
  output logic [1:0]  status
);

  logic [12:0]      block_end_type;
  tlvd_pkg::phase_t phase, phase_next;
  logic [7:0]       first_byte, first_byte_next;
  logic [12:0]      cur_type, cur_type_next;
  logic [15:0]      cur_len, cur_len_next;
  logic [15:0]      remaining, remaining_next;
  logic             block_open, block_open_next;

  logic [1:0]       role_c, status_c;
  logic [7:0]       byte_c;
  logic             done_c, bdone_c, header_end;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    phase_next      = phase;
    first_byte_next = first_byte;
    cur_type_next   = cur_type;
    cur_len_next    = cur_len;
    remaining_next  = remaining;
    block_open_next = block_open;
    role_c          = tlvd_pkg::ROLE_HEADER;
    status_c        = tlvd_pkg::STATUS_OK;
    byte_c          = in_byte;
    done_c          = 1'b0;
    bdone_c         = 1'b0;
    header_end      = 1'b0;
    if (end_of_input) begin
      role_c = tlvd_pkg::ROLE_END;
      byte_c = 8'h00;
      if (phase != tlvd_pkg::PH_H0) begin
        status_c = tlvd_pkg::STATUS_TRUNCATED;
      end else if (block_open) begin
        status_c = tlvd_pkg::STATUS_UNTERMINATED;
      end else begin
        status_c = tlvd_pkg::STATUS_CLEAN_END;
      end
      phase_next      = tlvd_pkg::PH_H0;
      first_byte_next = 8'h00;
      cur_type_next   = 13'h0000;
      cur_len_next    = 16'h0000;
      remaining_next  = 16'h0000;
      block_open_next = 1'b0;
    end else begin
      unique case (phase)
        tlvd_pkg::PH_H0: begin
          first_byte_next = in_byte;
          cur_len_next    = 16'h0000;
          if (in_byte[7]) begin
            cur_type_next = {in_byte[4:0] & tlvd_pkg::SHORT_TYPE_MASK, 8'h00};
          end else begin
            cur_type_next = {8'h00, in_byte[4:0] & tlvd_pkg::SHORT_TYPE_MASK};
          end
          phase_next = tlvd_pkg::PH_H1;
        end
        tlvd_pkg::PH_H1: begin
          if (first_byte[7]) begin
            cur_type_next = {first_byte[4:0], in_byte};
            phase_next    = tlvd_pkg::PH_H2;
          end else begin
            cur_len_next = {8'h00, in_byte};
            header_end   = 1'b1;
          end
        end
        tlvd_pkg::PH_H2: begin
          cur_len_next = {in_byte, 8'h00};
          phase_next   = tlvd_pkg::PH_H3;
        end
        tlvd_pkg::PH_H3: begin
          cur_len_next = {cur_len[15:8], in_byte};
          header_end   = 1'b1;
        end
        tlvd_pkg::PH_PAY: begin
          role_c         = tlvd_pkg::ROLE_PAYLOAD;
          remaining_next = remaining - 16'd1;
          if (remaining_next == 16'h0000) begin
            done_c     = 1'b1;
            phase_next = tlvd_pkg::PH_H0;
          end
        end
        default: begin
          phase_next = tlvd_pkg::PH_H0;
        end
      endcase
      // zero-length payload ends the element on its last header byte
      if (header_end) begin
        remaining_next = cur_len_next;
        if (cur_len_next == 16'h0000) begin
          done_c     = 1'b1;
          phase_next = tlvd_pkg::PH_H0;
        end else begin
          phase_next = tlvd_pkg::PH_PAY;
        end
      end
      if (done_c) begin
        bdone_c         = (cur_type_next == block_end_type);
        block_open_next = !bdone_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_end_type <= tlvd_pkg::BLOCK_END_TYPE_RESET;
      phase          <= tlvd_pkg::PH_H0;
      first_byte     <= 8'h00;
      cur_type       <= 13'h0000;
      cur_len        <= 16'h0000;
      remaining      <= 16'h0000;
      block_open     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_end_type <= cfg_data;
      end
      if (accept) begin
        phase      <= phase_next;
        first_byte <= first_byte_next;
        cur_type   <= cur_type_next;
        cur_len    <= cur_len_next;
        remaining  <= remaining_next;
        block_open <= block_open_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, end reports zero every field but role and status
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte       <= byte_c;
      byte_role      <= role_c;
      element_type   <= end_of_input ? 13'h0000 : cur_type_next;
      header_flags   <= end_of_input ? 3'b000 : first_byte_next[7:5];
      element_length <= end_of_input ? 16'h0000 : cur_len_next;
      element_done   <= done_c;
      block_done     <= bdone_c;
      status         <= status_c;
    end
  end

endmodule

@@ src/tlvd_checker.sv @@
module tlvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [1:0]  byte_role,
  input logic [12:0] element_type,
  input logic [2:0]  header_flags,
  input logic [15:0] element_length,
  input logic        element_done,
  input logic        block_done,
  input logic [1:0]  status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_role)
      && $stable(element_type) && $stable(header_flags) && $stable(element_length)
      && $stable(status))
    else $error("stalled result changed");

  a_block_needs_element: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_done |-> element_done && byte_role != tlvd_pkg::ROLE_END)
    else $error("block_done without element_done");

  a_end_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == tlvd_pkg::ROLE_END |-> out_byte == 8'h00 && !element_done
      && element_length == 16'h0000 && status != tlvd_pkg::STATUS_OK)
    else $error("malformed end report");

  // each accepted request gives a valid result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

endmodule

bind tlv8_tlv16_stream_deframer tlvd_checker u_tlvd_checker (.*);
